FILE: hdl/scfp_pkg.sv
// Shared constants, codes and the per-class entry layout of the size-class free-list policy.
package scfp_pkg;

    localparam int NUM_CLASSES = 192;
    localparam int COUNT_BITS  = 16;
    localparam int IDX_W       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;

    localparam logic [31:0] MAX_BYTES   = 32'(NUM_CLASSES * 8 - 8);
    localparam logic [31:0] CLASS_LIMIT = 32'(NUM_CLASSES);

    localparam logic [COUNT_BITS-1:0] CNT_MAX       = '1;
    localparam logic [COUNT_BITS-1:0] MIN_THRESHOLD = COUNT_BITS'(64);

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TRIM  = 2'd2
    } t_opcode;

    typedef enum logic [2:0] {
        ACT_HIT     = 3'd0,
        ACT_MISS    = 3'd1,
        ACT_KEPT    = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_TRIMMED = 3'd4,
        ACT_BAD     = 3'd5
    } t_action;

    typedef struct packed {
        logic                  active;
        logic [COUNT_BITS-1:0] mark_prev;
        logic [COUNT_BITS-1:0] mark_now;
        logic [COUNT_BITS-1:0] limit;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: hdl/scfp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module scfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/size_class_freelist_policy.sv
// Top level of the size-class free-list policy: per-class counters, limits and low-water marks.
//
// Requests enter on the input channel (i_valid / o_stall) and each one gives exactly one
// result item on the output channel (o_valid / i_stall). An item is taken at a clock edge
// where valid is high and stall is low.
// The class table lives in one RAM with a registered read port. An accepted item issues its
// read at once; the update stage then updates the entry and writes it back, and the result
// lands in the output register, which sets o_valid. One item can be accepted every cycle
// while the receiver does not stall. Back-to-back requests to the same class read the last
// written entry from a forwarding register, so the RAM read-modify-write loop needs no stall.
// Synchronous active-low reset clears all control state, the outstanding-block counter and
// one valid bit per class; a class whose valid bit is clear reads as all zero, so the block
// accepts items as soon as reset is released.
// When the receiver stalls, the result is held in the output register; the item in the
// update stage then waits, and o_stall rises only once both places are full.
module size_class_freelist_policy (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_opcode,
    input  logic [10:0] i_request_bytes,
    input  logic [7:0]  i_class_sel,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [7:0]  o_class_out,
    output logic [15:0] o_released_count,
    output logic [15:0] o_limit_out,
    output logic [31:0] o_outstanding
);

    import scfp_pkg::*;

    // Update stage
    logic             r_s1_valid;
    t_opcode          r_s1_op;
    logic             r_s1_ok;
    logic [7:0]       r_s1_cls;
    logic [IDX_W-1:0] r_s1_idx;

    // Last entry written, for forwarding
    logic             r_wr_valid;
    logic [IDX_W-1:0] r_wr_idx;
    t_entry           r_wr_data;

    logic [NUM_CLASSES-1:0] r_valid;
    logic [31:0]            r_live;

    // Output register
    logic        r_o_valid;
    t_action     r_o_action;
    logic [7:0]  r_o_cls;
    logic [15:0] r_o_rel;
    logic [15:0] r_o_lim;
    logic [31:0] r_o_live;

    logic             out_free;
    logic             s1_go;
    logic             accept;
    t_opcode          in_op;
    logic             in_ok;
    logic [7:0]       in_cls;
    logic [IDX_W-1:0] in_idx;

    logic [ENTRY_W-1:0] ram_q;
    t_entry             cur;
    t_entry             n_entry;
    logic               we;
    t_action            n_action;
    logic [7:0]         n_cls;
    logic [COUNT_BITS-1:0] n_rel;
    logic [COUNT_BITS-1:0] n_lim_out;
    logic [31:0]        n_live;
    logic [COUNT_BITS-1:0] thr;
    logic [COUNT_BITS-1:0] dec_count;
    logic [31:0]        rel_wide;
    logic [31:0]        lim_wide;

    assign out_free = !r_o_valid || !i_stall;
    assign s1_go    = r_s1_valid && out_free;
    assign o_stall  = r_s1_valid && !s1_go;
    assign accept   = i_valid && !o_stall;

    // Decode the incoming item: which class it touches and whether it is legal.
    always_comb begin
        in_op = t_opcode'(i_opcode);
        in_ok = 1'b0;
        in_cls = i_class_sel;
        case (i_opcode)
            OP_ALLOC: begin
                in_cls = 8'(i_request_bytes >> 3);
                in_ok  = !(32'(i_request_bytes) > MAX_BYTES);
            end
            OP_FREE, OP_TRIM: begin
                in_ok = 32'(i_class_sel) < CLASS_LIMIT;
            end
            default: begin
                in_ok = 1'b0;
            end
        endcase
        in_idx = IDX_W'(in_cls);
    end

    scfp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CLASSES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_s1_idx),
        .i_wdata (n_entry),
        .i_re    (accept),
        .i_raddr (in_idx),
        .o_rdata (ram_q)
    );

    // The forwarding register always holds the newest write, so a class match there wins
    // over the RAM, whether or not that write raced this item's read.
    always_comb begin
        if (r_wr_valid && (r_wr_idx == r_s1_idx)) begin
            cur = r_wr_data;
        end else if (r_valid[r_s1_idx]) begin
            cur = t_entry'(ram_q);
        end else begin
            cur = '0;
        end
    end

    always_comb begin
        n_entry   = cur;
        we        = s1_go && r_s1_ok;
        n_action  = ACT_BAD;
        n_cls     = 8'd0;
        n_rel     = '0;
        n_lim_out = '0;
        n_live    = r_live;
        thr       = cur.limit >> 3;
        dec_count = cur.count - COUNT_BITS'(1);
        if (thr < MIN_THRESHOLD) begin
            thr = MIN_THRESHOLD;
        end
        if (r_s1_ok) begin
            n_cls = r_s1_cls;
            case (r_s1_op)
                OP_ALLOC: begin
                    if (cur.count != '0) begin
                        n_entry.count = dec_count;
                        if (dec_count < cur.mark_now) begin
                            n_entry.mark_now = dec_count;
                        end
                        n_action = ACT_HIT;
                    end else begin
                        if (cur.limit != CNT_MAX) begin
                            n_entry.limit = cur.limit + COUNT_BITS'(1);
                        end
                        n_entry.active = 1'b1;
                        n_action = ACT_MISS;
                    end
                    if (r_live != 32'hFFFF_FFFF) begin
                        n_live = r_live + 32'd1;
                    end
                end
                OP_FREE: begin
                    if (r_live != 32'd0) begin
                        n_live = r_live - 32'd1;
                    end
                    if (cur.count >= cur.limit) begin
                        n_action = ACT_RELEASE;
                    end else begin
                        n_entry.count = cur.count + COUNT_BITS'(1);
                        n_action = ACT_KEPT;
                    end
                end
                OP_TRIM: begin
                    n_action = ACT_TRIMMED;
                    if (cur.active) begin
                        if (cur.mark_now > thr) begin
                            if (cur.mark_now <= cur.limit) begin
                                n_entry.limit = cur.limit - (cur.mark_now - (thr >> 1));
                            end else if (cur.mark_now >= cur.mark_prev) begin
                                if (cur.count > cur.limit) begin
                                    n_rel = cur.count - cur.limit;
                                    n_entry.count = cur.limit;
                                end
                            end
                        end
                        n_entry.mark_prev = cur.mark_now;
                        n_entry.mark_now  = n_entry.count;
                    end
                end
                default: begin
                    n_action = ACT_BAD;
                end
            endcase
            n_lim_out = n_entry.limit;
        end else if (r_s1_op == OP_FREE || r_s1_op == OP_TRIM) begin
            // A class number beyond the table is echoed back with the error.
            n_cls = r_s1_cls;
        end
    end

    assign rel_wide = 32'(n_rel);
    assign lim_wide = 32'(n_lim_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_wr_valid <= 1'b0;
            r_valid    <= '0;
            r_live     <= 32'd0;
            r_o_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (we) begin
                r_wr_valid         <= 1'b1;
                r_valid[r_s1_idx] <= 1'b1;
            end
            if (s1_go) begin
                r_live    <= n_live;
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= in_op;
            r_s1_ok  <= in_ok;
            r_s1_cls <= in_cls;
            r_s1_idx <= in_idx;
        end
        if (we) begin
            r_wr_idx  <= r_s1_idx;
            r_wr_data <= n_entry;
        end
        if (s1_go) begin
            r_o_action <= n_action;
            r_o_cls    <= n_cls;
            r_o_rel    <= rel_wide[15:0];
            r_o_lim    <= lim_wide[15:0];
            r_o_live   <= n_live;
        end
    end

    assign o_valid          = r_o_valid;
    assign o_action         = r_o_action;
    assign o_class_out      = r_o_cls;
    assign o_released_count = r_o_rel;
    assign o_limit_out      = r_o_lim;
    assign o_outstanding    = r_o_live;

endmodule
